>>> sv/mfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mfa_pkg;

   // quotient bits kept by the divider, divider datapath width, tolerance width
   localparam int unsigned QW   = 33;
   localparam int unsigned DW   = 64;
   localparam int unsigned EpsW = 16;

   typedef logic signed [31:0] elem_type;

   localparam elem_type MaxElem = 32'sh7fff_ffff;
   localparam elem_type MinElem = 32'sh8000_0000;

   typedef enum logic [3:0] {
      CMD_ADD       = 4'd0,
      CMD_SUB       = 4'd1,
      CMD_MUL       = 4'd2,
      CMD_SCALE     = 4'd3,
      CMD_DIV       = 4'd4,
      CMD_NEGATE    = 4'd5,
      CMD_DET       = 4'd6,
      CMD_TRANSPOSE = 4'd7,
      CMD_INVERSE   = 4'd8,
      CMD_EQUAL     = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NEAR = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   // queued item: command, operands and the multiplier operand pairs
   typedef struct packed {
      cmd_type            cmd;
      elem_type [3:0]     a;
      elem_type [3:0]     b;
      elem_type [7:0]     mx;
      elem_type [7:0]     my;
   } item_type;

   // control that rides along with the divider lanes
   typedef struct packed {
      cmd_type            cmd;
      elem_type [3:0]     r;
      logic               sat;
      logic               eq;
      logic               near;
      logic [3:0]         neg;
      logic [3:0]         ovf;
      logic [DW-1:0]      d;
   } ctl_type;

   typedef struct packed {
      logic [DW-1:0]      rem;
      logic [QW-1:0]      q;
   } lane_type;

   typedef struct packed {
      elem_type           val;
      logic               sat;
   } sat_type;

   function automatic sat_type sat32(input logic signed [65:0] v);
      sat_type res;
      res.sat = (v[65:31] != {35{v[31]}});
      res.val = res.sat ? (v[65] ? MinElem : MaxElem) : elem_type'(v[31:0]);
      return res;
   endfunction

endpackage
`default_nettype wire

>>> sv/mfa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mfa_queue
   import mfa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type item_in,
   input  wire logic     pop,
   output item_type      item_out,
   output logic          empty,
   output logic          full
);

   item_type   entry_ff [2];
   item_type   entry_in [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign item_out = entry_ff[rd_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      entry_in        = entry_ff;
      if (do_push) begin
         entry_in[wr_ff] = item_in;
      end
      wr_in    = wr_ff ^ do_push;
      rd_in    = rd_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/mfa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mfa_front
   import mfa_pkg::*;
(
   input  wire logic           start,
   input  wire logic           queue_full,
   input  wire logic [3:0]     command,
   input  wire elem_type [3:0] a,
   input  wire elem_type [3:0] b,
   output logic                busy,
   output logic                push,
   output item_type            item
);

   cmd_type cmd;

   assign cmd  = cmd_type'(command);
   assign busy = queue_full;
   assign push = start & ~queue_full;

   // pick multiplier operand pairs for the back end
   always_comb begin
      item.cmd = cmd;
      item.a   = a;
      item.b   = b;
      item.mx  = '0;
      item.my  = '0;
      unique case (cmd) inside
         CMD_MUL: begin
            item.mx[0] = a[0]; item.my[0] = b[0];
            item.mx[1] = a[1]; item.my[1] = b[2];
            item.mx[2] = a[0]; item.my[2] = b[1];
            item.mx[3] = a[1]; item.my[3] = b[3];
            item.mx[4] = a[2]; item.my[4] = b[0];
            item.mx[5] = a[3]; item.my[5] = b[2];
            item.mx[6] = a[2]; item.my[6] = b[1];
            item.mx[7] = a[3]; item.my[7] = b[3];
         end
         CMD_SCALE: begin
            item.mx[0] = a[0]; item.my[0] = b[0];
            item.mx[2] = a[1]; item.my[2] = b[0];
            item.mx[4] = a[2]; item.my[4] = b[0];
            item.mx[6] = a[3]; item.my[6] = b[0];
         end
         CMD_DET, CMD_INVERSE: begin
            item.mx[0] = a[0]; item.my[0] = a[3];
            item.mx[1] = a[1]; item.my[1] = a[2];
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

>>> sv/mfa_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module mfa_div_stage
   import mfa_pkg::*;
#(
   parameter int unsigned BIT = 0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           valid_in,
   input  wire ctl_type        ctl_in,
   input  wire lane_type [3:0] lane_in,
   output logic                valid_out,
   output ctl_type             ctl_out,
   output lane_type [3:0]      lane_out
);

   logic [DW+QW-1:0] dshift;
   logic             fits [4];
   lane_type [3:0]   lane_in_next;
   logic             valid_ff;
   ctl_type          ctl_ff;
   lane_type [3:0]   lane_ff;

   assign dshift = {{QW{1'b0}}, ctl_in.d} << BIT;

   // one restoring step per lane
   always_comb begin
      lane_in_next = lane_in;
      for (int i = 0; i < 4; i++) begin
         fits[i] = ({{QW{1'b0}}, lane_in[i].rem} >= dshift);
         if (fits[i]) begin
            lane_in_next[i].rem    = lane_in[i].rem - dshift[DW-1:0];
            lane_in_next[i].q[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff  <= ctl_in;
      lane_ff <= lane_in_next;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid_out = valid_ff;
   assign ctl_out   = ctl_ff;
   assign lane_out  = lane_ff;

endmodule
`default_nettype wire

>>> sv/mfa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mfa_back
   import mfa_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [EpsW-1:0] epsilon,
   input  wire logic            valid_in,
   input  wire item_type        item_in,
   output logic                 rsp_valid,
   output elem_type [3:0]       rsp_r,
   output logic                 rsp_equal,
   output status_type           rsp_status
);

   // ---- stage 1: products and the add-class ops
   logic                     s1_valid_ff;
   ctl_type                  s1_ctl_ff, s1_ctl_in;
   elem_type [3:0]           s1_a_ff;
   elem_type                 s1_b0_ff;
   logic signed [63:0]       s1_prod_ff [8];
   logic signed [63:0]       s1_prod_in [8];

   logic signed [32:0]       add_v [4];
   logic signed [32:0]       sub_v [4];
   logic signed [32:0]       neg_v [4];
   logic [32:0]              diff_mag [4];
   sat_type                  add_s [4];
   sat_type                  sub_s [4];
   sat_type                  neg_s [4];
   logic                     close [4];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         s1_prod_in[i] = $signed(item_in.mx[i]) * $signed(item_in.my[i]);
      end
      for (int i = 0; i < 4; i++) begin
         add_v[i]    = 33'($signed(item_in.a[i])) + 33'($signed(item_in.b[i]));
         sub_v[i]    = 33'($signed(item_in.a[i])) - 33'($signed(item_in.b[i]));
         neg_v[i]    = -33'($signed(item_in.a[i]));
         add_s[i]    = sat32(66'(add_v[i]));
         sub_s[i]    = sat32(66'(sub_v[i]));
         neg_s[i]    = sat32(66'(neg_v[i]));
         diff_mag[i] = sub_v[i][32] ? 33'(-sub_v[i]) : 33'(sub_v[i]);
         close[i]    = (diff_mag[i] <= 33'(epsilon));
      end
      s1_ctl_in     = '0;
      s1_ctl_in.cmd = item_in.cmd;
      unique case (item_in.cmd) inside
         CMD_ADD: begin
            for (int i = 0; i < 4; i++) s1_ctl_in.r[i] = add_s[i].val;
            s1_ctl_in.sat = add_s[0].sat | add_s[1].sat | add_s[2].sat | add_s[3].sat;
         end
         CMD_SUB: begin
            for (int i = 0; i < 4; i++) s1_ctl_in.r[i] = sub_s[i].val;
            s1_ctl_in.sat = sub_s[0].sat | sub_s[1].sat | sub_s[2].sat | sub_s[3].sat;
         end
         CMD_NEGATE: begin
            for (int i = 0; i < 4; i++) s1_ctl_in.r[i] = neg_s[i].val;
            s1_ctl_in.sat = neg_s[0].sat | neg_s[1].sat | neg_s[2].sat | neg_s[3].sat;
         end
         CMD_TRANSPOSE: begin
            s1_ctl_in.r[0] = item_in.a[0];
            s1_ctl_in.r[1] = item_in.a[2];
            s1_ctl_in.r[2] = item_in.a[1];
            s1_ctl_in.r[3] = item_in.a[3];
         end
         CMD_EQUAL: begin
            s1_ctl_in.eq = close[0] & close[1] & close[2] & close[3];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff  <= s1_ctl_in;
      s1_a_ff    <= item_in.a;
      s1_b0_ff   <= item_in.b[0];
      s1_prod_ff <= s1_prod_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= valid_in;
      end
   end

   // ---- stage 2: pair sums (difference for the determinant and the inverse)
   logic                     s2_valid_ff;
   ctl_type                  s2_ctl_ff;
   elem_type [3:0]           s2_a_ff;
   elem_type                 s2_b0_ff;
   logic signed [64:0]       s2_sum_ff [4];
   logic signed [64:0]       s2_sum_in [4];
   logic                     use_diff;

   assign use_diff = (s1_ctl_ff.cmd == CMD_DET) || (s1_ctl_ff.cmd == CMD_INVERSE);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (use_diff) begin
            s2_sum_in[k] = 65'(s1_prod_ff[2*k]) - 65'(s1_prod_ff[2*k+1]);
         end else begin
            s2_sum_in[k] = 65'(s1_prod_ff[2*k]) + 65'(s1_prod_ff[2*k+1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_ctl_ff <= s1_ctl_ff;
      s2_a_ff   <= s1_a_ff;
      s2_b0_ff  <= s1_b0_ff;
      s2_sum_ff <= s2_sum_in;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // ---- stage 3: floor and clamp, divider setup
   logic                     s3_valid_ff;
   ctl_type                  s3_ctl_ff, s3_ctl_in;
   logic [DW-1:0]            s3_num_ff [4];
   logic [DW-1:0]            s3_num_in [4];
   sat_type                  prod_s [4];
   logic signed [64:0]       divisor;
   logic [DW-1:0]            dmag;
   logic signed [32:0]       numer [4];
   logic [32:0]              nmag [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_s[k] = sat32(66'(s2_sum_ff[k] >>> FRAC_BITS));
      end
      if (s2_ctl_ff.cmd == CMD_DIV) begin
         divisor  = 65'($signed(s2_b0_ff));
         numer[0] = 33'($signed(s2_a_ff[0]));
         numer[1] = 33'($signed(s2_a_ff[1]));
         numer[2] = 33'($signed(s2_a_ff[2]));
         numer[3] = 33'($signed(s2_a_ff[3]));
      end else begin
         // inverse: adjugate over the floored determinant
         divisor  = s2_sum_ff[0] >>> FRAC_BITS;
         numer[0] = 33'($signed(s2_a_ff[3]));
         numer[1] = -33'($signed(s2_a_ff[1]));
         numer[2] = -33'($signed(s2_a_ff[2]));
         numer[3] = 33'($signed(s2_a_ff[0]));
      end
      dmag = divisor[64] ? DW'(-divisor) : DW'(divisor);
      for (int k = 0; k < 4; k++) begin
         nmag[k]      = numer[k][32] ? 33'(-numer[k]) : 33'(numer[k]);
         s3_num_in[k] = DW'(nmag[k][31:0]) << FRAC_BITS;
      end
      s3_ctl_in = s2_ctl_ff;
      unique case (s2_ctl_ff.cmd) inside
         CMD_MUL, CMD_SCALE: begin
            for (int k = 0; k < 4; k++) s3_ctl_in.r[k] = prod_s[k].val;
            s3_ctl_in.sat = prod_s[0].sat | prod_s[1].sat | prod_s[2].sat | prod_s[3].sat;
         end
         CMD_DET: begin
            s3_ctl_in.r[0] = prod_s[0].val;
            s3_ctl_in.sat  = prod_s[0].sat;
         end
         CMD_DIV, CMD_INVERSE: begin
            s3_ctl_in.d    = dmag;
            s3_ctl_in.near = (dmag <= DW'(epsilon));
            for (int k = 0; k < 4; k++) begin
               s3_ctl_in.neg[k] = numer[k][32] ^ divisor[64];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s3_ctl_ff <= s3_ctl_in;
      s3_num_ff <= s3_num_in;
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---- stage 4: quotient range check, load divider lanes
   logic                     div_valid [QW+1];
   ctl_type                  div_ctl   [QW+1];
   lane_type [3:0]           div_lane  [QW+1];
   logic                     s4_valid_ff;
   ctl_type                  s4_ctl_ff, s4_ctl_in;
   lane_type [3:0]           s4_lane_ff, s4_lane_in;

   always_comb begin
      s4_ctl_in = s3_ctl_ff;
      for (int k = 0; k < 4; k++) begin
         s4_ctl_in.ovf[k]   = ((s3_num_ff[k] >> QW) >= s3_ctl_ff.d);
         s4_lane_in[k].rem = s3_num_ff[k];
         s4_lane_in[k].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      s4_ctl_ff  <= s4_ctl_in;
      s4_lane_ff <= s4_lane_in;
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign div_valid[0] = s4_valid_ff;
   assign div_ctl[0]   = s4_ctl_ff;
   assign div_lane[0]  = s4_lane_ff;

   for (genvar g = 0; g < QW; g++) begin : g_div
      mfa_div_stage #(
         .BIT (QW - 1 - g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (div_valid[g]),
         .ctl_in    (div_ctl[g]),
         .lane_in   (div_lane[g]),
         .valid_out (div_valid[g+1]),
         .ctl_out   (div_ctl[g+1]),
         .lane_out  (div_lane[g+1])
      );
   end

   // ---- output stage: sign, clamp, status
   ctl_type                  fin_ctl;
   lane_type [3:0]           fin_lane;
   elem_type [3:0]           out_r_in;
   logic                     out_sat_in;
   logic                     q_big [4];
   status_type               out_status_in;
   logic                     out_valid_ff;
   elem_type [3:0]           out_r_ff;
   logic                     out_equal_ff;
   status_type               out_status_ff;

   assign fin_ctl  = div_ctl[QW];
   assign fin_lane = div_lane[QW];

   always_comb begin
      out_r_in   = fin_ctl.r;
      out_sat_in = fin_ctl.sat;
      for (int k = 0; k < 4; k++) begin
         q_big[k] = fin_ctl.neg[k] ?
                    (fin_lane[k].q[32] | (fin_lane[k].q[31] & (|fin_lane[k].q[30:0]))) :
                    (|fin_lane[k].q[32:31]);
      end
      if ((fin_ctl.cmd == CMD_DIV) || (fin_ctl.cmd == CMD_INVERSE)) begin
         out_sat_in = 1'b0;
         for (int k = 0; k < 4; k++) begin
            if (fin_ctl.near) begin
               out_r_in[k] = '0;
            end else if (fin_ctl.ovf[k] | q_big[k]) begin
               out_r_in[k] = fin_ctl.neg[k] ? MinElem : MaxElem;
               out_sat_in  = 1'b1;
            end else if (fin_ctl.neg[k]) begin
               out_r_in[k] = elem_type'(-fin_lane[k].q[31:0]);
            end else begin
               out_r_in[k] = elem_type'(fin_lane[k].q[31:0]);
            end
         end
      end
      if (fin_ctl.near) begin
         out_status_in = ST_NEAR;
      end else if (out_sat_in) begin
         out_status_in = ST_SAT;
      end else begin
         out_status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      out_r_ff      <= out_r_in;
      out_equal_ff  <= fin_ctl.eq;
      out_status_ff <= out_status_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid[QW];
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_r      = out_r_ff;
   assign rsp_equal  = out_equal_ff;
   assign rsp_status = out_status_ff;

endmodule
`default_nettype wire

>>> sv/matrix2x2_fixed_alu.sv
// 2x2 matrix unit on signed fixed-point elements (FRAC_BITS fractional bits).
// Pulse start with a command and matrices A and B (b00 doubles as the scalar);
// the item is taken on any clock where start is high and busy is low. One item
// can be taken every clock. Each result shows on the rsp_ ports for exactly
// one clock, flagged by rsp_valid, in order; the receiver cannot stall the
// unit, so it must take every beat. The unit is built around the 33-step
// restoring divider pipeline (one quotient bit a stage) that serves divide and
// inverse; all commands go through it so order holds.
// epsilon sits at byte address 0 of the APB-style port and should be written
// only with no items in flight.
`timescale 1ns / 1ps
`default_nettype none
module matrix2x2_fixed_alu
   import mfa_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [3:0]         req_command,
   input  wire logic signed [31:0] req_a00,
   input  wire logic signed [31:0] req_a01,
   input  wire logic signed [31:0] req_a10,
   input  wire logic signed [31:0] req_a11,
   input  wire logic signed [31:0] req_b00,
   input  wire logic signed [31:0] req_b01,
   input  wire logic signed [31:0] req_b10,
   input  wire logic signed [31:0] req_b11,
   // result channel
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_r00,
   output logic signed [31:0]      rsp_r01,
   output logic signed [31:0]      rsp_r10,
   output logic signed [31:0]      rsp_r11,
   output logic                    rsp_equal,
   output logic [1:0]              rsp_status,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [1:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam logic [1:0] AddrEpsilon = 2'd0;

   // epsilon register, reset to one LSB
   logic [EpsW-1:0] epsilon_ff, epsilon_in;
   logic            csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & (paddr == AddrEpsilon);
   assign epsilon_in = csr_write ? pwdata[EpsW-1:0] : epsilon_ff;
   assign prdata    = (paddr == AddrEpsilon) ? 32'(epsilon_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EpsW'(1);
      end else begin
         epsilon_ff <= epsilon_in;
      end
   end

   // front: take the beat, pick multiplier operands
   logic     queue_full;
   logic     queue_empty;
   logic     push;
   item_type front_item;
   item_type back_item;

   mfa_front u_front (
      .start      (start),
      .queue_full (queue_full),
      .command    (req_command),
      .a          ({req_a11, req_a10, req_a01, req_a00}),
      .b          ({req_b11, req_b10, req_b01, req_b00}),
      .busy       (busy),
      .push       (push),
      .item       (front_item)
   );

   // two-entry decoupling queue; the back end drains one item per clock
   mfa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_item),
      .pop      (~queue_empty),
      .item_out (back_item),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // back: multiply, combine, divide, clamp
   elem_type [3:0] rsp_r;
   status_type     status;

   mfa_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .epsilon    (epsilon_ff),
      .valid_in   (~queue_empty),
      .item_in    (back_item),
      .rsp_valid  (rsp_valid),
      .rsp_r      (rsp_r),
      .rsp_equal  (rsp_equal),
      .rsp_status (status)
   );

   assign rsp_r00    = rsp_r[0];
   assign rsp_r01    = rsp_r[1];
   assign rsp_r10    = rsp_r[2];
   assign rsp_r11    = rsp_r[3];
   assign rsp_status = 2'(status);

endmodule
`default_nettype wire
